// ===== src/assert_macros.svh =====
// Assertion macros for the line rasterizer.
// Needs signals clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CLR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
`define CLR_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: reset check failed");
`else
`define CLR_ASSERT(lbl, prop)
`define CLR_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== src/clr_pkg.sv =====
// Shared types and constants for the clipped line rasterizer.
// No dependencies.
package clr_pkg;

  localparam int COORD_BITS = 16;
  localparam int CLIP_BITS  = 13;
  localparam int EDGE_BITS  = CLIP_BITS - 1;
  localparam int COLOR_BITS = 32;

  localparam int DX_BITS  = COORD_BITS + 1;   // |x1-x0|, unsigned
  localparam int DYN_BITS = COORD_BITS + 2;   // -|y1-y0|, signed
  localparam int ERR_BITS = COORD_BITS + 3;   // error term, signed
  localparam int VIS_W    = (COORD_BITS > CLIP_BITS + 2) ? COORD_BITS : CLIP_BITS + 2;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_LEFT   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_TOP    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_HEIGHT = 2'd3;

  localparam logic [CLIP_BITS-1:0] CLIP_WIDTH_RST  = CLIP_BITS'(1024);
  localparam logic [CLIP_BITS-1:0] CLIP_HEIGHT_RST = CLIP_BITS'(768);

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [EDGE_BITS-1:0] left;
    logic [EDGE_BITS-1:0] top;
    logic [CLIP_BITS-1:0] width;
    logic [CLIP_BITS-1:0] height;
  } clip_cfg_t;

  typedef struct packed {
    logic                  action;
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
    logic [COLOR_BITS-1:0] color;
  } cmd_t;

  // pixel leaving the stepper, before clip and end tests
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] tx;
    logic [COORD_BITS-1:0] ty;
    logic [COLOR_BITS-1:0] color;
  } beat_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  visible;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pix_t;

endpackage

// ===== src/clr_front.sv =====
// Front end: accepts requests with their start/step action and queues them for the stepper.
// Depends on clr_pkg.
module clr_front
  import clr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  cmd_t in_cmd,
  input  logic cmd_pop,
  output logic cmd_valid,
  output cmd_t cmd
);

  cmd_t             q_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CW-1:0] cnt_r, cnt_nxt;
  logic             wr_en, rd_en;

  assign full      = (cnt_r == CQ_CW'(CQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CQ_CW'(wr_en) - CQ_CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// ===== src/clr_step.sv =====
// Bresenham stepper: holds the line state, takes queued requests, issues pixels.
// Depends on clr_pkg.
module clr_step
  import clr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cmd_valid,
  input  cmd_t  cmd,
  output logic  cmd_pop,
  input  logic  room,
  output logic  beat_v,
  output beat_t beat
);

  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic                  sxn_r, sxn_nxt, syn_r, syn_nxt;
  logic [DX_BITS-1:0]    dx_r, dx_nxt;
  logic [DYN_BITS-1:0]   dyn_r, dyn_nxt;
  logic [ERR_BITS-1:0]   err_r, err_nxt;
  logic [ERR_BITS-1:0]   sum_r, sum_nxt;
  logic [COLOR_BITS-1:0] color_r, color_nxt;
  logic                  beat_v_r;
  beat_t                 beat_r, beat_nxt;

  logic                  busy, is_step, drop, fire;
  logic [DX_BITS-1:0]    xf, xr, yf, yr, dx0;
  logic [DYN_BITS-1:0]   dyn0;
  logic [ERR_BITS-1:0]   err0, err_pdy, err_pdx, err_pboth;
  logic [ERR_BITS:0]     e2;
  logic                  go_x, go_y;

  // the line is live until the end point has been issued
  assign busy    = (cur_x_r != tgt_x_r) || (cur_y_r != tgt_y_r);
  assign is_step = (cmd.action == ACT_STEP);
  assign drop    = is_step && !busy;
  assign fire    = cmd_valid && !drop && room;
  assign cmd_pop = cmd_valid && (drop || room);

  always_comb begin
    // start setup: both differences in parallel, pick by sign
    xf   = DX_BITS'($signed(cmd.x1)) - DX_BITS'($signed(cmd.x0));
    xr   = DX_BITS'($signed(cmd.x0)) - DX_BITS'($signed(cmd.x1));
    yf   = DX_BITS'($signed(cmd.y1)) - DX_BITS'($signed(cmd.y0));
    yr   = DX_BITS'($signed(cmd.y0)) - DX_BITS'($signed(cmd.y1));
    dx0  = xf[DX_BITS-1] ? xr : xf;
    dyn0 = yf[DX_BITS-1] ? DYN_BITS'($signed(yf)) : DYN_BITS'($signed(yr));
    err0 = ERR_BITS'(dx0) + ERR_BITS'($signed(dyn0));

    // step: all candidate error updates in parallel with the compares
    e2        = {err_r, 1'b0};
    go_x      = $signed(e2) >= $signed((ERR_BITS+1)'($signed(dyn_r)));
    go_y      = $signed(e2) <= $signed((ERR_BITS+1)'(dx_r));
    err_pdy   = err_r + ERR_BITS'($signed(dyn_r));
    err_pdx   = err_r + ERR_BITS'(dx_r);
    err_pboth = err_r + sum_r;

    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    tgt_x_nxt = tgt_x_r;
    tgt_y_nxt = tgt_y_r;
    sxn_nxt   = sxn_r;
    syn_nxt   = syn_r;
    dx_nxt    = dx_r;
    dyn_nxt   = dyn_r;
    err_nxt   = err_r;
    sum_nxt   = sum_r;
    color_nxt = color_r;

    if (fire) begin
      if (!is_step) begin
        cur_x_nxt = cmd.x0;
        cur_y_nxt = cmd.y0;
        tgt_x_nxt = cmd.x1;
        tgt_y_nxt = cmd.y1;
        sxn_nxt   = !($signed(cmd.x0) < $signed(cmd.x1));
        syn_nxt   = !($signed(cmd.y0) < $signed(cmd.y1));
        dx_nxt    = dx0;
        dyn_nxt   = dyn0;
        err_nxt   = err0;
        sum_nxt   = err0;
        color_nxt = cmd.color;
      end else begin
        if (go_x) begin
          cur_x_nxt = sxn_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
        end
        if (go_y) begin
          cur_y_nxt = syn_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
        end
        case ({go_x, go_y})
          2'b11:   err_nxt = err_pboth;
          2'b10:   err_nxt = err_pdy;
          2'b01:   err_nxt = err_pdx;
          default: err_nxt = err_r;
        endcase
      end
    end

    beat_nxt.x     = cur_x_nxt;
    beat_nxt.y     = cur_y_nxt;
    beat_nxt.tx    = tgt_x_nxt;
    beat_nxt.ty    = tgt_y_nxt;
    beat_nxt.color = color_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      tgt_x_r  <= '0;
      tgt_y_r  <= '0;
      sxn_r    <= 1'b0;
      syn_r    <= 1'b0;
      dx_r     <= '0;
      dyn_r    <= '0;
      err_r    <= '0;
      sum_r    <= '0;
      color_r  <= '0;
      beat_v_r <= 1'b0;
    end else begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      tgt_x_r  <= tgt_x_nxt;
      tgt_y_r  <= tgt_y_nxt;
      sxn_r    <= sxn_nxt;
      syn_r    <= syn_nxt;
      dx_r     <= dx_nxt;
      dyn_r    <= dyn_nxt;
      err_r    <= err_nxt;
      sum_r    <= sum_nxt;
      color_r  <= color_nxt;
      beat_v_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      beat_r <= beat_nxt;
    end
  end

  assign beat_v = beat_v_r;
  assign beat   = beat_r;

endmodule

// ===== src/clr_out.sv =====
// Back end: clip and end-point tests on each pixel, then the result queue.
// Depends on clr_pkg.
module clr_out
  import clr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  clip_cfg_t clip,
  input  logic      beat_v,
  input  beat_t     beat,
  output logic      room,
  output logic      empty,
  input  logic      pop,
  output pix_t      head
);

  pix_t             q_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic             rd_en;
  pix_t             pix;
  logic [VIS_W-1:0] xe, ye, lft, rgt, top, bot;

  always_comb begin
    xe  = VIS_W'($signed(beat.x));
    ye  = VIS_W'($signed(beat.y));
    lft = VIS_W'(clip.left);
    top = VIS_W'(clip.top);
    rgt = VIS_W'((CLIP_BITS+1)'(clip.left) + (CLIP_BITS+1)'(clip.width));
    bot = VIS_W'((CLIP_BITS+1)'(clip.top) + (CLIP_BITS+1)'(clip.height));

    pix.x       = beat.x;
    pix.y       = beat.y;
    pix.visible = ($signed(xe) >= $signed(lft)) && ($signed(xe) < $signed(rgt)) &&
                  ($signed(ye) >= $signed(top)) && ($signed(ye) < $signed(bot));
    pix.color   = beat.color;
    pix.last    = (beat.x == beat.tx) && (beat.y == beat.ty);
  end

  // reserve a slot for the pixel already in flight
  assign room  = (cnt_r + OQ_CW'(beat_v)) < OQ_CW'(OQ_DEPTH);
  assign empty = (cnt_r == '0);
  assign head  = q_r[rd_ptr_r];
  assign rd_en = pop && !empty;

  always_comb begin
    wr_ptr_nxt = beat_v ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + OQ_CW'(beat_v) - OQ_CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_v) begin
      q_r[wr_ptr_r] <= pix;
    end
  end

endmodule

// ===== src/clipped_line_rasterizer.sv =====
// Top level of the clipped line rasterizer: clip registers, front queue,
// stepper and result queue. Depends on clr_pkg, clr_front, clr_step, clr_out.
//
//   channel  handshake          payload
//   input    push / full        in_action, in_start_x/y, in_end_x/y, in_color_word
//   result   empty / pop        out_pixel_x/y, out_visible, out_pixel_color, out_last
//   config   cfg_we             cfg_index, cfg_data
//
// One request per cycle sustained while the result queue has room; a start, or a step
// on a live line, yields its pixel via the front queue, stepper register and result
// queue. Throughput is set by the error-term update in the stepper.
// rst_n is synchronous; both queues come up empty and the stepper idle.
// A full result queue stalls the stepper; the front queue keeps taking requests
// until its four entries are used. Steps that arrive while idle are dropped.
`include "assert_macros.svh"

module clipped_line_rasterizer
  import clr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic                    in_action,
  input  logic [COORD_BITS-1:0]   in_start_x,
  input  logic [COORD_BITS-1:0]   in_start_y,
  input  logic [COORD_BITS-1:0]   in_end_x,
  input  logic [COORD_BITS-1:0]   in_end_y,
  input  logic [COLOR_BITS-1:0]   in_color_word,
  output logic                    empty,
  input  logic                    pop,
  output logic [COORD_BITS-1:0]   out_pixel_x,
  output logic [COORD_BITS-1:0]   out_pixel_y,
  output logic                    out_visible,
  output logic [COLOR_BITS-1:0]   out_pixel_color,
  output logic                    out_last,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CLIP_BITS-1:0]    cfg_data
);

  clip_cfg_t               clip_r, clip_nxt;
  cmd_t                    in_cmd, cmd;
  logic                    cmd_valid, cmd_pop;
  logic                    room, beat_v;
  beat_t                   beat;
  pix_t                    head;
  logic                    start_go;
  logic [2*COORD_BITS-1:0] start_xy;

  always_comb begin
    clip_nxt = clip_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLIP_LEFT:   clip_nxt.left   = cfg_data[EDGE_BITS-1:0];
        CFG_CLIP_TOP:    clip_nxt.top    = cfg_data[EDGE_BITS-1:0];
        CFG_CLIP_WIDTH:  clip_nxt.width  = cfg_data;
        CFG_CLIP_HEIGHT: clip_nxt.height = cfg_data;
        default:         clip_nxt = clip_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r.left   <= '0;
      clip_r.top    <= '0;
      clip_r.width  <= CLIP_WIDTH_RST;
      clip_r.height <= CLIP_HEIGHT_RST;
    end else begin
      clip_r <= clip_nxt;
    end
  end

  always_comb begin
    in_cmd.action = in_action;
    in_cmd.x0     = in_start_x;
    in_cmd.y0     = in_start_y;
    in_cmd.x1     = in_end_x;
    in_cmd.y1     = in_end_y;
    in_cmd.color  = in_color_word;
  end

  clr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_cmd    (in_cmd),
    .cmd_pop   (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  clr_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .room      (room),
    .beat_v    (beat_v),
    .beat      (beat)
  );

  clr_out u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .clip   (clip_r),
    .beat_v (beat_v),
    .beat   (beat),
    .room   (room),
    .empty  (empty),
    .pop    (pop),
    .head   (head)
  );

  assign out_pixel_x     = head.x;
  assign out_pixel_y     = head.y;
  assign out_visible     = head.visible;
  assign out_pixel_color = head.color;
  assign out_last        = head.last;

  assign start_go = cmd_valid && cmd_pop && (cmd.action == ACT_START);
  assign start_xy = {cmd.x0, cmd.y0};

  `CLR_ASSERT(a_accept_queued, (push && !full) |=> cmd_valid)
  `CLR_ASSERT(a_start_issues, start_go |=> (beat_v && {beat.x, beat.y} == $past(start_xy)))
  `CLR_ASSERT(a_beat_lands, beat_v |=> !empty)
  `CLR_ASSERT_RST(a_reset_clear, !rst_n |=> (empty && !full && !beat_v))

endmodule

// ===== verif/clipped_line_rasterizer_test.sv =====
// Self-checking testbench for clipped_line_rasterizer: a directed table, then random lines
// under several clip settings, every pixel checked against the table or a line predictor.
// Depends on clr_pkg and the RTL of the block only.
module clipped_line_rasterizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import clr_pkg::*;

  localparam int PHASES        = 8;
  localparam int PIXELS_PER_PH = 75;
  localparam int SETTLE        = 8;
  localparam int LONG_HOLD     = 200;

  typedef struct packed {
    logic typed;
    cmd_t req;
    pix_t px;
  } stim_row_t;

  localparam stim_row_t DIRECTED [25] = '{
    // step right after reset: nothing comes out
    '{1'b0, '{ACT_STEP, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 32'hCAFEF00D}, '0},
    // zero-length line: one pixel, marked last
    '{1'b1, '{ACT_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'hFFFFFFFF},
            '{16'h0000, 16'h0000, 1'b1, 32'hFFFFFFFF, 1'b1}},
    '{1'b0, '{ACT_STEP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF}, '0},
    // last pixel inside the reset clip rectangle, then the first one outside
    '{1'b1, '{ACT_START, 16'd1023, 16'd767, 16'd1024, 16'd768, 32'h00000000},
            '{16'd1023, 16'd767, 1'b1, 32'h00000000, 1'b0}},
    '{1'b1, '{ACT_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h00000000},
            '{16'd1024, 16'd768, 1'b0, 32'h00000000, 1'b1}},
    // full-span diagonals, each dropped by the next start
    '{1'b1, '{ACT_START, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 32'hA5A5A5A5},
            '{16'h8000, 16'h8000, 1'b0, 32'hA5A5A5A5, 1'b0}},
    '{1'b0, '{ACT_STEP, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 32'h00000005}, '0},
    '{1'b0, '{ACT_STEP, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h80000000}, '0},
    '{1'b1, '{ACT_START, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 32'h5A5A5A5A},
            '{16'h7FFF, 16'h7FFF, 1'b0, 32'h5A5A5A5A, 1'b0}},
    '{1'b0, '{ACT_STEP, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFFFFFF}, '0},
    '{1'b0, '{ACT_STEP, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 32'h55555555}, '0},
    '{1'b1, '{ACT_START, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 32'h0F0F0F0F},
            '{16'h7FFF, 16'h8000, 1'b0, 32'h0F0F0F0F, 1'b0}},
    '{1'b0, '{ACT_STEP, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 32'hAAAAAAAA}, '0},
    // steep line running toward the origin, to its end
    '{1'b1, '{ACT_START, 16'd2, 16'd3, 16'd0, 16'd0, 32'h12345678},
            '{16'd2, 16'd3, 1'b1, 32'h12345678, 1'b0}},
    '{1'b0, '{ACT_STEP, 16'h0F0F, 16'hF0F0, 16'h0F0F, 16'hF0F0, 32'h0F0F0F0F}, '0},
    '{1'b0, '{ACT_STEP, 16'hF0F0, 16'h0F0F, 16'hF0F0, 16'h0F0F, 32'hF0F0F0F0}, '0},
    '{1'b0, '{ACT_STEP, 16'h3333, 16'hCCCC, 16'h3333, 16'hCCCC, 32'h33333333}, '0},
    // vertical line across y = 0, then a step while idle
    '{1'b1, '{ACT_START, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 32'h87654321},
            '{16'h0000, 16'hFFFF, 1'b0, 32'h87654321, 1'b0}},
    '{1'b0, '{ACT_STEP, 16'hCCCC, 16'h3333, 16'hCCCC, 16'h3333, 32'hCCCCCCCC}, '0},
    '{1'b0, '{ACT_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h00000000}, '0},
    '{1'b0, '{ACT_STEP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF}, '0},
    // horizontal line across x = 0
    '{1'b1, '{ACT_START, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 32'hDEADBEEF},
            '{16'hFFFF, 16'h0000, 1'b0, 32'hDEADBEEF, 1'b0}},
    '{1'b0, '{ACT_STEP, 16'h1111, 16'h2222, 16'h4444, 16'h8888, 32'h11111111}, '0},
    '{1'b0, '{ACT_STEP, 16'h8888, 16'h4444, 16'h2222, 16'h1111, 32'h88888888}, '0},
    '{1'b1, '{ACT_START, 16'd100, 16'd100, 16'd100, 16'd100, 32'h00000000},
            '{16'd100, 16'd100, 1'b1, 32'h00000000, 1'b1}}
  };

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    push = 1'b0;
  logic                    full;
  logic                    in_action = ACT_STEP;
  logic [COORD_BITS-1:0]   in_start_x = '0;
  logic [COORD_BITS-1:0]   in_start_y = '0;
  logic [COORD_BITS-1:0]   in_end_x = '0;
  logic [COORD_BITS-1:0]   in_end_y = '0;
  logic [COLOR_BITS-1:0]   in_color_word = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic [COORD_BITS-1:0]   out_pixel_x;
  logic [COORD_BITS-1:0]   out_pixel_y;
  logic                    out_visible;
  logic [COLOR_BITS-1:0]   out_pixel_color;
  logic                    out_last;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_CLIP_LEFT;
  logic [CLIP_BITS-1:0]    cfg_data = '0;

  // predictor state: clip rectangle and the line being traced
  int   clip_l = 0;
  int   clip_t = 0;
  int   clip_w = int'(CLIP_WIDTH_RST);
  int   clip_h = int'(CLIP_HEIGHT_RST);
  int   pos_x = 0, pos_y = 0, tgt_x = 0, tgt_y = 0;
  int   run_dx = 0, run_dy_neg = 0, err_acc = 0;
  bit   x_back = 1'b0, y_back = 1'b0, drawing = 1'b0;
  logic [COLOR_BITS-1:0] hue = '0;

  pix_t pending_pixels [$];
  int   errors = 0;
  int   requests_sent = 0;
  int   pixels_due = 0;
  int   pixels_checked = 0;
  int   long_holds = 0;
  int   clip_settings = 0;
  bit   no_idle = 1'b0;
  bit   hold_request = 1'b0;

  clipped_line_rasterizer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_action       (in_action),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_color_word   (in_color_word),
    .empty           (empty),
    .pop             (pop),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_visible     (out_visible),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  // Advance the traced line by one request; returns 1 when a pixel comes out.
  function automatic bit next_pixel(input cmd_t req, output pix_t px);
    int e2;
    px = '0;
    if (req.action == ACT_START) begin
      pos_x      = int'($signed(req.x0));
      pos_y      = int'($signed(req.y0));
      tgt_x      = int'($signed(req.x1));
      tgt_y      = int'($signed(req.y1));
      run_dx     = (tgt_x >= pos_x) ? tgt_x - pos_x : pos_x - tgt_x;
      run_dy_neg = (tgt_y >= pos_y) ? pos_y - tgt_y : tgt_y - pos_y;
      x_back     = !(pos_x < tgt_x);
      y_back     = !(pos_y < tgt_y);
      err_acc    = run_dx + run_dy_neg;
      hue        = req.color;
    end else if (!drawing) begin
      return 1'b0;
    end else begin
      e2 = 2 * err_acc;
      if (e2 >= run_dy_neg) begin
        err_acc += run_dy_neg;
        pos_x   += x_back ? -1 : 1;
      end
      if (e2 <= run_dx) begin
        err_acc += run_dx;
        pos_y   += y_back ? -1 : 1;
      end
    end
    px.x       = pos_x[COORD_BITS-1:0];
    px.y       = pos_y[COORD_BITS-1:0];
    px.visible = pos_x >= clip_l && pos_x < clip_l + clip_w &&
                 pos_y >= clip_t && pos_y < clip_t + clip_h;
    px.color   = hue;
    px.last    = (pos_x == tgt_x) && (pos_y == tgt_y);
    drawing    = !px.last;
    return 1'b1;
  endfunction

  function automatic int fit_coord(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Offer one request after a random gap and hold it until accepted.
  task automatic send_request(input cmd_t req, input bit typed, input pix_t typed_px);
    pix_t px;
    int   gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    in_action     <= req.action;
    in_start_x    <= req.x0;
    in_start_y    <= req.y0;
    in_end_x      <= req.x1;
    in_end_y      <= req.y1;
    in_color_word <= req.color;
    do @(posedge clk); while (full);
    requests_sent++;
    if (next_pixel(req, px)) begin
      pending_pixels.push_back(typed ? typed_px : px);
      pixels_due++;
    end
  endtask

  // Stop offering, wait for every pixel, then let dropped steps clear the pipe.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CLIP_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_CLIP_LEFT:   clip_l = int'(data[EDGE_BITS-1:0]);
      CFG_CLIP_TOP:    clip_t = int'(data[EDGE_BITS-1:0]);
      CFG_CLIP_WIDTH:  clip_w = int'(data);
      CFG_CLIP_HEIGHT: clip_h = int'(data);
      default: ;
    endcase
  endtask

  task automatic set_clip(input logic [CLIP_BITS-1:0] l, input logic [CLIP_BITS-1:0] t,
                          input logic [CLIP_BITS-1:0] w, input logic [CLIP_BITS-1:0] h);
    write_reg(CFG_CLIP_LEFT, l);
    write_reg(CFG_CLIP_TOP, t);
    write_reg(CFG_CLIP_WIDTH, w);
    write_reg(CFG_CLIP_HEIGHT, h);
    cfg_we <= 1'b0;
    clip_settings++;
  endtask

  // One line: a start, then mostly exactly enough steps to reach the end point;
  // some lines are dropped early, some get extra steps that the block ignores.
  task automatic random_line();
    cmd_t req;
    int   x0, y0, x1, y1, ax, ay, len, n, mode;
    bit   wide;
    wide = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 3) == 0) begin
      x0 = int'($signed(16'($urandom)));
      y0 = int'($signed(16'($urandom)));
    end else begin
      x0 = clip_l - 16 + int'($urandom_range(0, clip_w + 32));
      y0 = clip_t - 16 + int'($urandom_range(0, clip_h + 32));
    end
    if (wide) begin
      x1 = fit_coord(x0 + int'($urandom_range(0, 4000)) - 2000);
      y1 = fit_coord(y0 + int'($urandom_range(0, 4000)) - 2000);
    end else begin
      x1 = fit_coord(x0 + int'($urandom_range(0, 24)) - 12);
      y1 = fit_coord(y0 + int'($urandom_range(0, 24)) - 12);
    end
    ax   = (x1 > x0) ? x1 - x0 : x0 - x1;
    ay   = (y1 > y0) ? y1 - y0 : y0 - y1;
    len  = (ax > ay) ? ax : ay;
    mode = $urandom_range(0, 5);
    if (mode == 0) n = (len == 0) ? 0 : $urandom_range(0, len - 1);
    else if (mode == 1) n = len + $urandom_range(1, 3);
    else n = len;
    if (wide && n > 40) n = 40;
    req.action = ACT_START;
    req.x0     = x0[COORD_BITS-1:0];
    req.y0     = y0[COORD_BITS-1:0];
    req.x1     = x1[COORD_BITS-1:0];
    req.y1     = y1[COORD_BITS-1:0];
    req.color  = $urandom;
    send_request(req, 1'b0, '0);
    repeat (n) begin
      req.action = ACT_STEP;
      req.x0     = 16'($urandom);
      req.y0     = 16'($urandom);
      req.x1     = 16'($urandom);
      req.y1     = 16'($urandom);
      req.color  = $urandom;
      send_request(req, 1'b0, '0);
    end
  endtask

  // result side: random pop gaps, one long hold-off on request
  initial begin
    int   lag;
    pix_t got;
    pix_t want;
    wait (rst_n === 1'b1);
    forever begin
      lag = no_idle ? 0 : $urandom_range(0, 8);
      if (hold_request) begin
        hold_request = 1'b0;
        lag = LONG_HOLD;
        long_holds++;
      end
      if (lag != 0) begin
        pop <= 1'b0;
        repeat (lag) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got = '{out_pixel_x, out_pixel_y, out_visible, out_pixel_color, out_last};
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, actual x=%h y=%h", $time,
                 got.x, got.y);
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", 32'(want.x), 32'(got.x));
        check_field("pixel_y", 32'(want.y), 32'(got.y));
        check_field("visible", 32'(want.visible), 32'(got.visible));
        check_field("pixel_color", want.color, got.color);
        check_field("last", 32'(want.last), 32'(got.last));
      end
      pixels_checked++;
    end
  end

  initial begin
    int goal;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(DIRECTED); i++)
      send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].px);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: set_clip('0, '0, '0, '0);
        1: set_clip('1, '1, '1, '1);
        2: set_clip('0, '0, 13'd4096, 13'd4096);
        default: set_clip(13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom));
      endcase
      no_idle = (ph == 3);
      // hold the result side so the block fills up and stalls its input
      if (ph == 2 || ph == 5) hold_request = 1'b1;
      goal = pixels_due + PIXELS_PER_PH;
      while (pixels_due < goal) random_line();
    end
    no_idle = 1'b0;
    drain();

    $display("%0d requests sent, %0d pixels checked under %0d clip settings,",
             requests_sent, pixels_checked, clip_settings);
    $display("including %0d long result stalls", long_holds);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule
